// ===== sv/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg
// Shared types and constants of the steering agent step block.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 31;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPEED = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FORCE = 2'd2;

  localparam logic [1:0] MODE_FLEE   = 2'd1;
  localparam logic [1:0] MODE_PURSUE = 2'd2;

  localparam logic CMD_PLACE = 1'b1;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_SQRT = 3'b010,
    OP_DIV  = 3'b100
  } sas_op_t;

endpackage

`default_nettype wire

// ===== sv/sas_unit.sv =====
// ----------------------------------------------------------------------------
// sas_unit
// Radix-2 arithmetic unit: shift-add multiply, digit-by-digit square root
// and restoring division, one bit per cycle; root and division share one compare path.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_unit
  import sas_pkg::*;
#(
  parameter int PW = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire sas_op_t       op,
  input  wire logic [PW-1:0] a,
  input  wire logic [PW-1:0] b,
  output logic               done,
  output logic [PW-1:0]      res
);

  localparam int HW = PW / 2;
  localparam int AW = PW + 2;
  localparam int CW = $clog2(PW + 1);

  sas_op_t        op_r;
  logic           busy;
  logic [CW-1:0]  cnt;
  logic [AW-1:0]  acc;
  logic [PW-1:0]  ma;
  logic [PW-1:0]  mb;
  logic [PW-1:0]  q;

  logic [AW-1:0]  rem_s;
  logic [AW-1:0]  trial;
  logic [AW:0]    diff;
  logic           ge;

  always_comb begin
    if (op_r == OP_SQRT) begin
      rem_s = {acc[AW-3:0], ma[PW-1:PW-2]};
      trial = {q, 2'b01};
    end else begin
      rem_s = {acc[AW-2:0], ma[PW-1]};
      trial = {2'b00, mb};
    end
    diff = {1'b0, rem_s} - {1'b0, trial};
    ge   = ~diff[AW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= OP_MUL;
    end else begin
      done <= 1'b0;
      if (start) begin
        op_r <= op;
        acc  <= '0;
        q    <= '0;
        ma   <= a;
        mb   <= b;
        cnt  <= (op == OP_DIV) ? CW'(PW) : CW'(HW);
        busy <= 1'b1;
      end else if (busy) begin
        unique case (op_r)
          OP_MUL: begin
            if (mb[0]) acc <= acc + {2'b00, ma};
            ma <= ma << 1;
            mb <= mb >> 1;
          end
          OP_SQRT: begin
            acc <= ge ? diff[AW-1:0] : rem_s;
            q   <= {q[PW-2:0], ge};
            ma  <= ma << 2;
          end
          OP_DIV: begin
            acc <= ge ? diff[AW-1:0] : rem_s;
            q   <= {q[PW-2:0], ge};
            ma  <= ma << 1;
          end
          default: ;
        endcase
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = (op_r == OP_MUL) ? acc[PW-1:0] : q;

endmodule

`default_nettype wire

// ===== sv/steering_agent_step.sv =====
// ----------------------------------------------------------------------------
// steering_agent_step
// Seek / flee / pursuit steering agent, one simulation tick per request.
// ----------------------------------------------------------------------------
// A place request loads location and velocity and answers without the
// arithmetic unit. A step request runs up to five vector passes (distance,
// pursuit offset, desired, steering limit, speed limit) on one bit-serial
// unit: each pass is two squares and then, as needed, a limit square, a root
// and two multiply/divide pairs. Input is refused while a request is in
// work; a finished result waits in the output register.
`default_nettype none

module steering_agent_step
  import sas_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // target_x, target_y, place_x, place_y, place_vx, place_vy
  input  wire logic [191:0]             s_tdata,
  // cmd
  input  wire logic                     s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // loc_x, loc_y, speed_x, speed_y
  output logic [127:0]                  m_tdata,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int MW = (W > 31) ? W : 31;
  localparam int HW = MW + 1;
  localparam int PW = 2 * HW;
  localparam int XW = ((W > 32) ? W : 32) + 2;

  localparam logic signed [XW-1:0] WMAX = XW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [XW-1:0] WMIN = -WMAX - XW'(1);
  localparam logic signed [XW-1:0] OMAX = XW'(64'h7FFF_FFFF);
  localparam logic signed [XW-1:0] OMIN = -OMAX - XW'(1);
  localparam logic [30:0] SPEED_RST = 31'(64'd10 << FRAC_BITS);
  localparam logic [30:0] FORCE_RST = 31'((64'd4 << FRAC_BITS) / 10);
  localparam logic signed [XW-1:0] MOTY_RAW = -(XW'(2) <<< FRAC_BITS);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_SQX  = 12'b000000000010,
    ST_SQY  = 12'b000000000100,
    ST_SQL  = 12'b000000001000,
    ST_ROOT = 12'b000000010000,
    ST_MULX = 12'b000000100000,
    ST_DIVX = 12'b000001000000,
    ST_MULY = 12'b000010000000,
    ST_DIVY = 12'b000100000000,
    ST_NEXT = 12'b001000000000,
    ST_DONE = 12'b010000000000,
    ST_WAIT = 12'b100000000000
  } state_t;

  typedef enum logic [4:0] {
    PH_DIST = 5'b00001,
    PH_MOT  = 5'b00010,
    PH_DES  = 5'b00100,
    PH_STR  = 5'b01000,
    PH_VEL  = 5'b10000
  } phase_t;

  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
    if (v > WMAX) return WMAX[W-1:0];
    if (v < WMIN) return WMIN[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic signed [XW-1:0] ext(input logic signed [W-1:0] v);
    return {{(XW-W){v[W-1]}}, v};
  endfunction

  function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
    return sat(ext(x) + ext(y));
  endfunction

  function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] y);
    return sat(ext(x) - ext(y));
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  function automatic logic signed [W-1:0] in_word(input logic [31:0] v);
    return sat({{(XW-32){v[31]}}, v});
  endfunction

  function automatic logic [31:0] out_word(input logic signed [W-1:0] v);
    logic signed [XW-1:0] e;
    e = ext(v);
    if (e > OMAX) return OMAX[31:0];
    if (e < OMIN) return OMIN[31:0];
    return e[31:0];
  endfunction

  state_t  state;
  phase_t  phase;
  logic    issued;
  logic [1:0]  steer_mode;
  logic [30:0] speed_limit;
  logic [30:0] force_limit;

  logic signed [W-1:0] pos_x, pos_y, mot_x, mot_y, prev_x, prev_y;
  logic signed [W-1:0] tgt_x, tgt_y, des_x, des_y, vx, vy;
  logic [MW-1:0] lim;
  logic [HW-1:0] len;
  logic [PW-1:0] n2;

  logic          u_start, u_done;
  sas_op_t       u_op;
  logic [PW-1:0] u_a, u_b, u_res;
  logic signed [W-1:0] scaled;
  logic signed [W-1:0] t_x, t_y, d_x, d_y;
  logic signed [W-1:0] nvx, nvy;

  sas_unit #(.PW(PW)) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (u_start),
    .op    (u_op),
    .a     (u_a),
    .b     (u_b),
    .done  (u_done),
    .res   (u_res)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  always_comb begin
    u_op = OP_MUL;
    u_a  = '0;
    u_b  = '0;
    unique case (state)
      ST_SQX:  begin u_a = PW'(mag(vx)); u_b = PW'(mag(vx)); end
      ST_SQY:  begin u_a = PW'(mag(vy)); u_b = PW'(mag(vy)); end
      ST_SQL:  begin u_a = PW'(lim); u_b = PW'(lim); end
      ST_ROOT: begin u_op = OP_SQRT; u_a = n2; end
      ST_MULX: begin u_a = PW'(mag(vx)); u_b = PW'(lim); end
      ST_MULY: begin u_a = PW'(mag(vy)); u_b = PW'(lim); end
      ST_DIVX, ST_DIVY: begin u_op = OP_DIV; u_a = n2; u_b = PW'(len); end
      default: ;
    endcase
    u_start = !issued && (state == ST_SQX || state == ST_SQY || state == ST_SQL ||
              state == ST_ROOT || state == ST_MULX || state == ST_DIVX ||
              state == ST_MULY || state == ST_DIVY);
  end

  always_comb begin
    logic signed [XW-1:0] qx;
    logic                 neg;
    qx     = XW'(u_res[MW-1:0]);
    neg    = (state == ST_DIVX) ? vx[W-1] : vy[W-1];
    scaled = sat(neg ? -qx : qx);
    t_x    = in_word(s_tdata[31:0]);
    t_y    = in_word(s_tdata[63:32]);
    d_x    = sub_s(t_x, pos_x);
    d_y    = sub_s(t_y, pos_y);
    nvx    = add_s(des_x, vx);
    nvy    = add_s(des_y, vy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_DES;
      issued      <= 1'b0;
      m_tvalid    <= 1'b0;
      steer_mode  <= '0;
      speed_limit <= SPEED_RST;
      force_limit <= FORCE_RST;
      pos_x       <= '0;
      pos_y       <= '0;
      mot_x       <= '0;
      mot_y       <= sat(MOTY_RAW);
      prev_x      <= '0;
      prev_y      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE:  steer_mode  <= cfg_data[1:0];
          REG_SPEED: speed_limit <= cfg_data;
          REG_FORCE: force_limit <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_WAIT) m_tvalid <= 1'b0;
      if (u_start) issued <= 1'b1;
      if (u_done)  issued <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == CMD_PLACE) begin
              pos_x <= in_word(s_tdata[95:64]);
              pos_y <= in_word(s_tdata[127:96]);
              mot_x <= in_word(s_tdata[159:128]);
              mot_y <= in_word(s_tdata[191:160]);
              state <= ST_DONE;
            end else begin
              tgt_x <= t_x;
              tgt_y <= t_y;
              state <= ST_SQX;
              if (steer_mode == MODE_FLEE) begin
                des_x <= sat(-ext(d_x));
                des_y <= sat(-ext(d_y));
                vx    <= sat(-ext(d_x));
                vy    <= sat(-ext(d_y));
                lim   <= MW'(speed_limit);
                phase <= PH_DES;
              end else begin
                des_x <= d_x;
                des_y <= d_y;
                vx    <= d_x;
                vy    <= d_y;
                lim   <= MW'(speed_limit);
                phase <= (steer_mode == MODE_PURSUE) ? PH_DIST : PH_DES;
              end
            end
          end
        end
        ST_SQX: if (u_done) begin
          n2    <= u_res;
          state <= ST_SQY;
        end
        ST_SQY: if (u_done) begin
          n2    <= n2 + u_res;
          state <= (phase == PH_STR || phase == PH_VEL) ? ST_SQL : ST_ROOT;
        end
        ST_SQL: if (u_done) begin
          state <= (n2 > u_res) ? ST_ROOT : ST_NEXT;
        end
        ST_ROOT: if (u_done) begin
          len <= u_res[HW-1:0];
          if (phase == PH_DIST) begin
            state <= ST_NEXT;
          end else if (u_res == '0) begin
            vx    <= '0;
            vy    <= '0;
            state <= ST_NEXT;
          end else begin
            state <= ST_MULX;
          end
        end
        ST_MULX: if (u_done) begin
          n2    <= u_res;
          state <= ST_DIVX;
        end
        ST_DIVX: if (u_done) begin
          vx    <= scaled;
          state <= ST_MULY;
        end
        ST_MULY: if (u_done) begin
          n2    <= u_res;
          state <= ST_DIVY;
        end
        ST_DIVY: if (u_done) begin
          vy    <= scaled;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          state <= ST_SQX;
          unique case (phase)
            PH_DIST: begin
              vx    <= sub_s(tgt_x, prev_x);
              vy    <= sub_s(tgt_y, prev_y);
              lim   <= MW'(len);
              phase <= PH_MOT;
            end
            PH_MOT: begin
              des_x  <= nvx;
              des_y  <= nvy;
              vx     <= nvx;
              vy     <= nvy;
              prev_x <= tgt_x;
              prev_y <= tgt_y;
              lim    <= MW'(speed_limit);
              phase  <= PH_DES;
            end
            PH_DES: begin
              vx    <= sub_s(vx, mot_x);
              vy    <= sub_s(vy, mot_y);
              lim   <= MW'(force_limit);
              phase <= PH_STR;
            end
            PH_STR: begin
              vx    <= add_s(mot_x, vx);
              vy    <= add_s(mot_y, vy);
              lim   <= MW'(speed_limit);
              phase <= PH_VEL;
            end
            default: begin
              mot_x <= vx;
              mot_y <= vy;
              pos_x <= add_s(pos_x, vx);
              pos_y <= add_s(pos_y, vy);
              state <= ST_DONE;
            end
          endcase
        end
        ST_DONE: state <= ST_WAIT;
        ST_WAIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {out_word(mot_y), out_word(mot_x),
                         out_word(pos_y), out_word(pos_x)};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !issued)
    else $error("arithmetic operation outstanding while idle");

  a_result_loads_once: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && (!m_tvalid || m_tready) |=> m_tvalid && state == ST_IDLE)
    else $error("result not presented on completion");

endmodule

`default_nettype wire

// ===== verif/steering_agent_step_checker.sv =====
// ----------------------------------------------------------------------------
// steering_agent_step_checker
// Watches the request, result and register channels of the steering agent,
// predicts each new location and velocity in Q16.16 and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_agent_step_checker
  import sas_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  input  wire logic                     s_tready,
  input  wire logic [191:0]             s_tdata,
  input  wire logic                     s_tuser,
  input  wire logic                     m_tvalid,
  input  wire logic                     m_tready,
  input  wire logic [127:0]             m_tdata,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] speed_y;
    logic [31:0] speed_x;
    logic [31:0] loc_y;
    logic [31:0] loc_x;
  } agent_out_t;

  agent_out_t    agent_q[$];
  logic [1:0]    mode;
  longint unsigned vmax, fmax;
  longint        pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, last_tx, last_ty;

  function automatic longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic logic [127:0] sq_sum(longint x, longint y);
    logic [127:0] ax, ay;
    ax = {64'd0, absval(x)};
    ay = {64'd0, absval(y)};
    return ax * ax + ay * ay;
  endfunction

  function automatic longint unsigned root(logic [127:0] n);
    logic [127:0] t;
    longint unsigned r;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'd0, r | (64'd1 << b)};
      if (t * t <= n) r = t[63:0];
    end
    return r;
  endfunction

  function automatic longint rescale(longint c, longint unsigned m, longint unsigned len);
    logic [127:0] p;
    longint v;
    p = {64'd0, absval(c)} * {64'd0, m};
    p = p / {64'd0, len};
    v = p[63:0];
    return clamp(c < 0 ? -v : v);
  endfunction

  task automatic set_len(inout longint x, inout longint y, input longint unsigned m);
    longint unsigned len;
    len = root(sq_sum(x, y));
    if (len == 0) begin
      x = 0;
      y = 0;
    end else begin
      x = rescale(x, m, len);
      y = rescale(y, m, len);
    end
  endtask

  task automatic cap(inout longint x, inout longint y, input longint unsigned lim);
    if (sq_sum(x, y) > {64'd0, lim} * {64'd0, lim}) set_len(x, y, lim);
  endtask

  function automatic longint word_in(logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  task automatic advance(input logic cmd, input logic [191:0] d);
    longint tx, ty, dx, dy, mx, my, sx, sy;
    longint unsigned reach;
    agent_out_t r;
    if (cmd == CMD_PLACE) begin
      pos_x = word_in(d[95:64]);
      pos_y = word_in(d[127:96]);
      vel_x = word_in(d[159:128]);
      vel_y = word_in(d[191:160]);
    end else begin
      tx = word_in(d[31:0]);
      ty = word_in(d[63:32]);
      dx = clamp(tx - pos_x);
      dy = clamp(ty - pos_y);
      if (mode == MODE_FLEE) begin
        dx = clamp(-dx);
        dy = clamp(-dy);
      end else if (mode == MODE_PURSUE) begin
        mx = clamp(tx - last_tx);
        my = clamp(ty - last_ty);
        reach = root(sq_sum(dx, dy));
        set_len(mx, my, reach);
        dx = clamp(dx + mx);
        dy = clamp(dy + my);
        last_tx = tx;
        last_ty = ty;
      end
      set_len(dx, dy, vmax);
      sx = clamp(dx - vel_x);
      sy = clamp(dy - vel_y);
      cap(sx, sy, fmax);
      acc_x = clamp(acc_x + sx);
      acc_y = clamp(acc_y + sy);
      vel_x = clamp(vel_x + acc_x);
      vel_y = clamp(vel_y + acc_y);
      cap(vel_x, vel_y, vmax);
      pos_x = clamp(pos_x + vel_x);
      pos_y = clamp(pos_y + vel_y);
      acc_x = 0;
      acc_y = 0;
    end
    r.loc_x = pos_x[31:0];
    r.loc_y = pos_y[31:0];
    r.speed_x = vel_x[31:0];
    r.speed_y = vel_y[31:0];
    agent_q.push_back(r);
  endtask

  task automatic compare(input string fname, input logic [31:0] exp_v, input logic [31:0] got);
    if (exp_v !== got) begin
      $error("%s: expected %0d, got %0d", fname, signed'(exp_v), signed'(got));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    agent_out_t e, a;
    if (rst) begin
      mode = 2'd0;
      vmax = 64'd655360;
      fmax = 64'd26214;
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = -131072;
      acc_x = 0; acc_y = 0; last_tx = 0; last_ty = 0;
      agent_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:  mode = cfg_data[1:0];
          REG_SPEED: vmax = {33'd0, cfg_data};
          REG_FORCE: fmax = {33'd0, cfg_data};
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        a = m_tdata;
        if (agent_q.size() == 0) begin
          $error("result with nothing expected: %h", m_tdata);
          fail_count++;
        end else begin
          e = agent_q.pop_front();
          compare("loc_x", e.loc_x, a.loc_x);
          compare("loc_y", e.loc_y, a.loc_y);
          compare("speed_x", e.speed_x, a.speed_x);
          compare("speed_y", e.speed_y, a.speed_y);
        end
      end
    end
    pending <= agent_q.size();
  end

  initial fail_count = 0;

endmodule

`default_nettype wire

// ===== verif/steering_agent_step_tb.sv =====
// ----------------------------------------------------------------------------
// steering_agent_step_tb
// Drives place and step requests and register writes into the steering agent
// under changing back-pressure; the checker module predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_agent_step_tb;
  import sas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic       CMD_STEP   = 1'b0;
  localparam int         WATCH_LIMIT = 40000;

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [191:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [127:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int fail_count, pending;
  int src_idle, sink_idle, sent, stall_cycles;
  bit hold_off;

  steering_agent_step u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  steering_agent_step_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCH_LIMIT) begin
      $display("steering_agent_step regression: fail");
      $finish;
    end
  end

  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 0;
        repeat (4000) @(posedge clk);
        hold_off = 0;
      end
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  task automatic send(input logic cmd, input logic [191:0] d);
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= d;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    sent++;
    if ($urandom_range(99) < src_idle) begin
      s_tvalid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [30:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain;
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int span);
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic logic [30:0] rnd_limit;
    case ($urandom_range(5))
      0: return 31'd0;
      1: return 31'h7fffffff;
      2: return 31'($urandom);
      default: return 31'($urandom_range(1 << 22));
    endcase
  endfunction

  task automatic rnd_request;
    logic [191:0] d;
    d = {rnd_coord(1 << 22), rnd_coord(1 << 22), rnd_coord(1 << 24), rnd_coord(1 << 24),
         rnd_coord(1 << 24), rnd_coord(1 << 24)};
    send(($urandom_range(4) == 0) ? CMD_PLACE : CMD_STEP, d);
  endtask

  initial begin
    logic [31:0] hi, lo;
    hi = 32'h7fffffff;
    lo = 32'h80000000;
    rst = 1;
    s_tvalid = 0; s_tuser = 0; s_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    src_idle = 36; sink_idle = 51; sent = 0; hold_off = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // defaults: reset velocity, then target on the agent
    send(CMD_STEP, {128'd0, 32'd0, 32'd0});
    send(CMD_STEP, {128'd0, 32'd655360, 32'd327680});
    send(CMD_PLACE, {32'd0, 32'd0, 32'd0, 32'd0, 64'd0});
    send(CMD_STEP, {128'd0, 32'd0, 32'd0});
    send(CMD_PLACE, {hi, hi, hi, hi, lo, lo});
    send(CMD_STEP, {128'd0, lo, lo});
    send(CMD_PLACE, {lo, lo, lo, lo, hi, hi});
    send(CMD_STEP, {128'd0, hi, hi});
    send(CMD_STEP, {128'hffffffff_ffffffff_ffffffff_ffffffff, lo, hi});
    drain();
    write_reg(REG_MODE, 31'(MODE_FLEE));
    send(CMD_STEP, {128'd0, 32'd100000, 32'd200000});
    send(CMD_STEP, {128'd0, lo, hi});
    drain();
    write_reg(REG_MODE, 31'(MODE_PURSUE));
    send(CMD_STEP, {128'd0, 32'd100000, 32'd200000});
    send(CMD_STEP, {128'd0, 32'd100000, 32'd200000});
    send(CMD_PLACE, {32'd65536, 32'd65536, 32'd0, 32'd0, 64'd0});
    send(CMD_STEP, {128'd0, lo, hi});
    send(CMD_STEP, {128'd0, hi, lo});
    drain();
    write_reg(REG_MODE, 31'(MODE_SPARE));
    write_reg(REG_SPEED, 31'h7fffffff);
    write_reg(REG_FORCE, 31'h7fffffff);
    send(CMD_STEP, {128'd0, 32'd500000, 32'd0});
    send(CMD_STEP, {128'd0, lo, lo});
    drain();
    write_reg(REG_SPEED, 31'd0);
    write_reg(REG_FORCE, 31'd0);
    send(CMD_STEP, {128'd0, 32'd500000, 32'd0});
    send(CMD_PLACE, {32'd65536, 32'd65536, 64'd0, 64'd0});
    send(CMD_STEP, {128'd0, 32'd0, 32'd0});
    drain();

    for (int blk = 0; blk < 8; blk++) begin
      if (blk == 3) begin src_idle = 51; sink_idle = 36; end
      if (blk == 6) begin src_idle = 0; sink_idle = 0; hold_off = 1; end
      write_reg(REG_MODE, 31'((blk < 4) ? blk[1:0] : $urandom_range(3)));
      write_reg(REG_SPEED, (blk == 0) ? 31'd655360 : rnd_limit());
      write_reg(REG_FORCE, (blk == 0) ? 31'd26214 : rnd_limit());
      repeat (50) rnd_request();
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d requests: place and step in all four steer modes,", sent);
    $display("limits from zero to full scale, with sender and receiver stalls");
    if (fail_count == 0) begin
      $display("steering_agent_step regression: pass");
    end else begin
      $display("steering_agent_step regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== steering_agent_step.f =====
sv/sas_pkg.sv
sv/sas_unit.sv
sv/steering_agent_step.sv
verif/steering_agent_step_checker.sv
verif/steering_agent_step_tb.sv
